>>> rtl/gcd_pkg.sv
package gcd_pkg;

  localparam int ANGLE_FRAC_BITS = 23;
  localparam int CORDIC_STAGES   = 32;
  localparam int AMP_BITS        = 56;
  localparam int ANG_BITS        = 60;

  // registers from accept to result, not counting the three cordic chains
  localparam int LAT_FIXED = 84;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] RAD_M  =
      (PI_Q60 / 64'd45) * 64'd64 + ((PI_Q60 % 64'd45) * 64'd64) / 64'd45;

  localparam logic [26:0] RECIP45 = 27'(((64'd1 << 32) + 64'd44) / 64'd45);

  localparam logic [34:0] DIST_MAX       = 35'd21991148575;
  localparam logic [32:0] RADIUS_K_RESET = 33'd6371000000;

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60 from the alternating series in Q62
  function automatic logic signed [63:0] atan_entry(input int i);
    logic signed [63:0] acc;
    logic [63:0]        term;
    int                 e;
    acc = '0;
    if (i == 0) begin
      return $signed((PI_Q60 + 64'd2) >> 2);
    end
    for (int k = 0; k < 64; k++) begin
      e = 62 - i * (2 * k + 1);
      if (e >= 0) begin
        term = udiv(64'd1 << e, 64'(2 * k + 1));
        if ((k & 1) != 0) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
    end
    return (acc + 64'sd2) >>> 2;
  endfunction

endpackage

>>> rtl/gcd_delay.sv
module gcd_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= d_i;
    for (int k = 1; k < DEPTH; k++) begin
      pipe_q[k] <= pipe_q[k-1];
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

>>> rtl/gcd_mul.sv
module gcd_mul #(
  parameter int SHIFT = 60,
  parameter bit ROUND = 1'b0
) (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  localparam logic [127:0] RND = ROUND ? (128'd1 << (SHIFT - 1)) : 128'd0;

  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [63:0]  lo_q, hi_q;
  logic [64:0]  mid_q;
  logic [127:0] full_d;
  logic [63:0]  p_q;

  always_ff @(posedge clk_i) begin
    p00_q <= a_i[31:0]  * b_i[31:0];
    p01_q <= a_i[31:0]  * b_i[63:32];
    p10_q <= a_i[63:32] * b_i[31:0];
    p11_q <= a_i[63:32] * b_i[63:32];
  end

  always_ff @(posedge clk_i) begin
    mid_q <= 65'(p01_q) + 65'(p10_q);
    lo_q  <= p00_q;
    hi_q  <= p11_q;
  end

  assign full_d = {hi_q, 64'd0} + (128'(mid_q) << 32) + 128'(lo_q) + RND;

  always_ff @(posedge clk_i) begin
    p_q <= full_d[SHIFT +: 64];
  end

  assign p_o = p_q;

endmodule

>>> rtl/gcd_cordic_cell.sv
module gcd_cordic_cell #(
  parameter int                 STAGE  = 0,
  parameter bit                 VECTOR = 1'b0,
  parameter logic signed [63:0] ATAN   = '0
) (
  input  logic               clk_i,
  input  logic signed [63:0] x_i,
  input  logic signed [63:0] y_i,
  input  logic signed [63:0] z_i,
  output logic signed [63:0] x_o,
  output logic signed [63:0] y_o,
  output logic signed [63:0] z_o
);

  logic signed [63:0] dx, dy;
  logic               dir;
  logic signed [63:0] x_q, y_q, z_q;

  assign dx  = y_i >>> STAGE;
  assign dy  = x_i >>> STAGE;
  assign dir = VECTOR ? y_i[63] : !z_i[63];

  always_ff @(posedge clk_i) begin
    if (dir) begin
      x_q <= x_i - dx;
      y_q <= y_i + dy;
      z_q <= z_i - ATAN;
    end else begin
      x_q <= x_i + dx;
      y_q <= y_i - dy;
      z_q <= z_i + ATAN;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

>>> rtl/gcd_div_cell.sv
module gcd_div_cell (
  input  logic                         clk_i,
  input  logic [63:0]                  n_i,
  input  logic [63:0]                  d_i,
  input  logic [gcd_pkg::ANG_BITS-1:0] q_i,
  output logic [63:0]                  n_o,
  output logic [63:0]                  d_o,
  output logic [gcd_pkg::ANG_BITS-1:0] q_o
);

  logic [63:0]                  n2;
  logic                         ge;
  logic [63:0]                  n_q, d_q;
  logic [gcd_pkg::ANG_BITS-1:0] q_q;

  assign n2 = {n_i[62:0], 1'b0};
  assign ge = n2 >= d_i;

  always_ff @(posedge clk_i) begin
    n_q <= ge ? n2 - d_i : n2;
    d_q <= d_i;
    q_q <= {q_i[gcd_pkg::ANG_BITS-2:0], ge};
  end

  assign n_o = n_q;
  assign d_o = d_q;
  assign q_o = q_q;

endmodule

>>> rtl/great_circle_distance.sv
// channel   direction  handshake                 beat
// command   in         start_i high, busy_o low  two points, lat/lon in degrees
// config    in         sphere_radius_m_we_i      sphere radius in meters
// result    out        done_o, one cycle         distance_mm_o
//
// one point pair per cycle; busy_o stays low
// each result passes through three cordic chains in series
// and the 60-cell divider that refines the final angle
// async reset clears the valid pipe and sets the radius to 6371000 m
// results are shown for one cycle and cannot be held off
module great_circle_distance #(
  parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS,
  parameter int CORDIC_STAGES   = gcd_pkg::CORDIC_STAGES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [30:0] first_latitude_i,
  input  logic signed [31:0] first_longitude_i,
  input  logic signed [30:0] second_latitude_i,
  input  logic signed [31:0] second_longitude_i,
  input  logic               sphere_radius_m_we_i,
  input  logic [22:0]        sphere_radius_m_i,
  output logic               done_o,
  output logic [34:0]        distance_mm_o
);

  localparam int N   = CORDIC_STAGES;
  localparam int F3  = ANGLE_FRAC_BITS + 3;
  localparam int HW  = 34 - F3;
  localparam int UW  = HW + 5;
  localparam int LAT = gcd_pkg::LAT_FIXED + 3 * CORDIC_STAGES;
  localparam int AB  = gcd_pkg::ANG_BITS;

  localparam logic signed [33:0] LAT_LIM  = 34'(64'd90 << ANGLE_FRAC_BITS);
  localparam logic signed [33:0] PER_HALF = 34'(64'd180 << ANGLE_FRAC_BITS);
  localparam logic [UW-1:0]      U_OFS    = UW'(64'd45 << (HW - 1));

  function automatic logic signed [33:0] clamp_lat(input logic signed [33:0] v);
    if (v > LAT_LIM) begin
      return LAT_LIM;
    end
    if (v < -LAT_LIM) begin
      return -LAT_LIM;
    end
    return v;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // control
  logic [LAT-1:0] vld_q;
  logic [32:0]    radius_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      radius_k_q <= gcd_pkg::RADIUS_K_RESET;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i};
      if (sphere_radius_m_we_i) begin
        radius_k_q <= 33'(33'(sphere_radius_m_i) * 33'd1000);
      end
    end
  end

  assign busy_o = 1'b0;
  assign done_o = vld_q[LAT-1];

  // angle preparation
  logic signed [33:0] lat1_w, lat2_w;
  logic signed [33:0] dlat_q, slat_q, lon_t_q;
  logic signed [33:0] dlat2_q, slat2_q, dlat3_q, slat3_q;
  logic [UW-1:0]      u_q, u3_q;
  logic [F3-1:0]      tlo_q, tlo3_q;
  logic [UW+26:0]     qprod_w;
  logic [HW-1:0]      q_q;
  logic [UW-1:0]      qmul_w;
  logic [5:0]         rem_w;
  logic signed [33:0] ang_q [3];
  logic [31:0]        mag5_q [3];
  logic [2:0]         neg5_q;
  logic [2:0]         neg8_w;
  logic [63:0]        hrad_w [3];
  logic signed [63:0] z0_q [3];

  assign lat1_w = clamp_lat(34'(first_latitude_i));
  assign lat2_w = clamp_lat(34'(second_latitude_i));

  always_ff @(posedge clk_i) begin
    dlat_q  <= lat2_w - lat1_w;
    slat_q  <= lat1_w + lat2_w;
    lon_t_q <= 34'(second_longitude_i) - 34'(first_longitude_i) + PER_HALF;
  end

  always_ff @(posedge clk_i) begin
    u_q     <= UW'(lon_t_q >>> F3) + U_OFS;
    tlo_q   <= lon_t_q[F3-1:0];
    dlat2_q <= dlat_q;
    slat2_q <= slat_q;
  end

  assign qprod_w = (UW+27)'(u_q) * (UW+27)'(gcd_pkg::RECIP45);

  always_ff @(posedge clk_i) begin
    q_q     <= qprod_w[32 +: HW];
    u3_q    <= u_q;
    tlo3_q  <= tlo_q;
    dlat3_q <= dlat2_q;
    slat3_q <= slat2_q;
  end

  assign qmul_w = UW'(UW'(q_q) * UW'(45));
  assign rem_w  = 6'(u3_q - qmul_w);

  always_ff @(posedge clk_i) begin
    ang_q[0] <= dlat3_q;
    ang_q[1] <= slat3_q;
    ang_q[2] <= 34'({rem_w, tlo3_q}) - PER_HALF;
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      mag5_q[j] <= 32'(ang_q[j][33] ? -ang_q[j] : ang_q[j]);
      neg5_q[j] <= ang_q[j][33];
    end
  end

  gcd_delay #(.WIDTH(3), .DEPTH(3)) u_neg_dly (
    .clk_i (clk_i),
    .d_i   (neg5_q),
    .q_o   (neg8_w)
  );

  // rotation chains: half lat difference, half lat sum, half lon difference
  logic signed [63:0] rx [3][N+1];
  logic signed [63:0] ry [3][N+1];
  logic signed [63:0] rz [3][N+1];

  for (genvar j = 0; j < 3; j++) begin : g_rot
    gcd_mul #(.SHIFT(9 + ANGLE_FRAC_BITS), .ROUND(1'b1)) u_rad_mul (
      .clk_i (clk_i),
      .a_i   (64'(mag5_q[j])),
      .b_i   (gcd_pkg::RAD_M),
      .p_o   (hrad_w[j])
    );

    assign rx[j][0] = 64'(64'd1 << gcd_pkg::AMP_BITS);
    assign ry[j][0] = '0;
    assign rz[j][0] = z0_q[j];

    for (genvar i = 0; i < N; i++) begin : g_cell
      gcd_cordic_cell #(
        .STAGE  (i),
        .VECTOR (1'b0),
        .ATAN   (gcd_pkg::atan_entry(i))
      ) u_cell (
        .clk_i (clk_i),
        .x_i   (rx[j][i]),
        .y_i   (ry[j][i]),
        .z_i   (rz[j][i]),
        .x_o   (rx[j][i+1]),
        .y_o   (ry[j][i+1]),
        .z_o   (rz[j][i+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      z0_q[j] <= neg8_w[j] ? -$signed(hrad_w[j]) : $signed(hrad_w[j]);
    end
  end

  // residual angle correction
  logic [63:0]        mx1_q [3];
  logic [63:0]        my1_q [3];
  logic [63:0]        mz1_q [3];
  logic signed [63:0] x1_q [3];
  logic signed [63:0] y1_q [3];
  logic [2:0]         syz1_q, sxz1_q;
  logic [129:0]       side_w [3];
  logic [63:0]        pyz_w [3];
  logic [63:0]        pxz_w [3];
  logic signed [63:0] co_q [3];
  logic signed [63:0] so_q [3];
  logic [63:0]        amc_q [3];
  logic [63:0]        ams_q [3];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      mx1_q[j]  <= mag64(rx[j][N]);
      my1_q[j]  <= mag64(ry[j][N]);
      mz1_q[j]  <= mag64(rz[j][N]);
      x1_q[j]   <= rx[j][N];
      y1_q[j]   <= ry[j][N];
      syz1_q[j] <= ry[j][N][63] ^ rz[j][N][63];
      sxz1_q[j] <= rx[j][N][63] ^ rz[j][N][63];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_res
    gcd_mul #(.SHIFT(AB), .ROUND(1'b0)) u_yz_mul (
      .clk_i (clk_i),
      .a_i   (my1_q[j]),
      .b_i   (mz1_q[j]),
      .p_o   (pyz_w[j])
    );

    gcd_mul #(.SHIFT(AB), .ROUND(1'b0)) u_xz_mul (
      .clk_i (clk_i),
      .a_i   (mx1_q[j]),
      .b_i   (mz1_q[j]),
      .p_o   (pxz_w[j])
    );

    gcd_delay #(.WIDTH(130), .DEPTH(3)) u_side_dly (
      .clk_i (clk_i),
      .d_i   ({x1_q[j], y1_q[j], syz1_q[j], sxz1_q[j]}),
      .q_o   (side_w[j])
    );
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      co_q[j] <= $signed(side_w[j][129:66])
               - (side_w[j][1] ? -$signed(pyz_w[j]) : $signed(pyz_w[j]));
      so_q[j] <= $signed(side_w[j][65:2])
               + (side_w[j][0] ? -$signed(pxz_w[j]) : $signed(pxz_w[j]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      amc_q[j] <= mag64(co_q[j]);
      ams_q[j] <= mag64(so_q[j]);
    end
  end

  // haversine terms and magnitudes
  logic [63:0]        u1_w, v1_w, u2_w, v2_w;
  logic signed [63:0] vx [2][N+1];
  logic signed [63:0] vy [2][N+1];
  logic signed [63:0] vz [2][N+1];
  logic signed [63:0] wx [N+1];
  logic signed [63:0] wy [N+1];
  logic signed [63:0] wz [N+1];

  gcd_mul #(.SHIFT(gcd_pkg::AMP_BITS), .ROUND(1'b0)) u_u1_mul (
    .clk_i (clk_i), .a_i (ams_q[0]), .b_i (amc_q[2]), .p_o (u1_w)
  );
  gcd_mul #(.SHIFT(gcd_pkg::AMP_BITS), .ROUND(1'b0)) u_v1_mul (
    .clk_i (clk_i), .a_i (amc_q[1]), .b_i (ams_q[2]), .p_o (v1_w)
  );
  gcd_mul #(.SHIFT(gcd_pkg::AMP_BITS), .ROUND(1'b0)) u_u2_mul (
    .clk_i (clk_i), .a_i (amc_q[0]), .b_i (amc_q[2]), .p_o (u2_w)
  );
  gcd_mul #(.SHIFT(gcd_pkg::AMP_BITS), .ROUND(1'b0)) u_v2_mul (
    .clk_i (clk_i), .a_i (ams_q[1]), .b_i (ams_q[2]), .p_o (v2_w)
  );

  assign vx[0][0] = $signed(u1_w);
  assign vy[0][0] = $signed(v1_w);
  assign vz[0][0] = '0;
  assign vx[1][0] = $signed(u2_w);
  assign vy[1][0] = $signed(v2_w);
  assign vz[1][0] = '0;

  for (genvar k = 0; k < 2; k++) begin : g_vec
    for (genvar i = 0; i < N; i++) begin : g_cell
      gcd_cordic_cell #(
        .STAGE  (i),
        .VECTOR (1'b1),
        .ATAN   (gcd_pkg::atan_entry(i))
      ) u_cell (
        .clk_i (clk_i),
        .x_i   (vx[k][i]),
        .y_i   (vy[k][i]),
        .z_i   (vz[k][i]),
        .x_o   (vx[k][i+1]),
        .y_o   (vy[k][i+1]),
        .z_o   (vz[k][i+1])
      );
    end
  end

  // central angle: atan2(sqrt(a), sqrt(1-a))
  assign wx[0] = vx[1][N];
  assign wy[0] = vx[0][N];
  assign wz[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_atan
    gcd_cordic_cell #(
      .STAGE  (i),
      .VECTOR (1'b1),
      .ATAN   (gcd_pkg::atan_entry(i))
    ) u_cell (
      .clk_i (clk_i),
      .x_i   (wx[i]),
      .y_i   (wy[i]),
      .z_i   (wz[i]),
      .x_o   (wx[i+1]),
      .y_o   (wy[i+1]),
      .z_o   (wz[i+1])
    );
  end

  // residual atan by long division y/x
  logic [63:0]   wymag_w;
  logic          fine_w;
  logic [63:0]   dn [AB+1];
  logic [63:0]   dd [AB+1];
  logic [AB-1:0] dq [AB+1];
  logic [63:0]   dn_q, dd_q;
  logic [65:0]   side0_q;
  logic [65:0]   side60_w;

  assign wymag_w = mag64(wy[N]);
  assign fine_w  = !wx[N][63] && (wx[N] != '0) && (wymag_w < 64'(wx[N]));

  always_ff @(posedge clk_i) begin
    dn_q    <= wymag_w;
    dd_q    <= 64'(wx[N]);
    side0_q <= {fine_w, wy[N][63], wz[N]};
  end

  assign dn[0] = dn_q;
  assign dd[0] = dd_q;
  assign dq[0] = '0;

  for (genvar i = 0; i < AB; i++) begin : g_div
    gcd_div_cell u_cell (
      .clk_i (clk_i),
      .n_i   (dn[i]),
      .d_i   (dd[i]),
      .q_i   (dq[i]),
      .n_o   (dn[i+1]),
      .d_o   (dd[i+1]),
      .q_o   (dq[i+1])
    );
  end

  gcd_delay #(.WIDTH(66), .DEPTH(AB)) u_ang_dly (
    .clk_i (clk_i),
    .d_i   (side0_q),
    .q_o   (side60_w)
  );

  // scale by radius
  logic signed [63:0] qs_w, psi_w;
  logic [63:0]        c_q;
  logic [63:0]        dist_w;
  logic [34:0]        dist_q;

  assign qs_w  = $signed(64'(dq[AB]));
  assign psi_w = $signed(side60_w[63:0])
               + (side60_w[65] ? (side60_w[64] ? -qs_w : qs_w) : 64'sd0);

  always_ff @(posedge clk_i) begin
    c_q <= psi_w[63] ? '0 : {psi_w[62:0], 1'b0};
  end

  gcd_mul #(.SHIFT(AB), .ROUND(1'b1)) u_dist_mul (
    .clk_i (clk_i),
    .a_i   (64'(radius_k_q)),
    .b_i   (c_q),
    .p_o   (dist_w)
  );

  always_ff @(posedge clk_i) begin
    dist_q <= (dist_w > 64'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : dist_w[34:0];
  end

  assign distance_mm_o = dist_q;

endmodule

>>> rtl/gcd_checker.sv
module gcd_checker #(
  parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [34:0] distance_mm_o
);

  localparam int LAT = gcd_pkg::LAT_FIXED + 3 * CORDIC_STAGES;

  a_beat_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("accepted beat gave no result");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without an accepted beat");

  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (distance_mm_o <= gcd_pkg::DIST_MAX))
    else $error("distance above maximum");

endmodule

bind great_circle_distance gcd_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_gcd_checker (.*);

>>> tb/sv/great_circle_distance_checker.sv
`timescale 1ns / 100ps

module great_circle_distance_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic signed [30:0] first_latitude_i,
  input  logic signed [31:0] first_longitude_i,
  input  logic signed [30:0] second_latitude_i,
  input  logic signed [31:0] second_longitude_i,
  input  logic               sphere_radius_m_we_i,
  input  logic [22:0]        sphere_radius_m_i,
  input  logic               done_o,
  input  logic [34:0]        distance_mm_o,
  output int                 mismatch_count,
  output int                 outstanding
);

  localparam int STAGES = 32;
  localparam int FRAC = 23;
  localparam logic [63:0] PI60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG_TO_RAD =
      (PI60 / 64'd45) * 64'd64 + ((PI60 % 64'd45) * 64'd64) / 64'd45;
  localparam logic [34:0] MAX_MM = 35'd21991148575;

  longint      arctan_q60[STAGES];
  logic [22:0] radius_m;
  logic [34:0] distance_q[$];

  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int s, input bit rnd);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (rnd) p = p + (128'd1 << (s - 1));
    p = p >> s;
    return p[63:0];
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint mul_q60(input longint a, input longint b);
    longint p;
    p = longint'(mul_shr(abs64(a), abs64(b), 60, 1'b0));
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic longint to_half_rad(input longint d);
    longint r;
    r = longint'(mul_shr(abs64(d), DEG_TO_RAD, 9 + FRAC, 1'b1));
    return d < 0 ? -r : r;
  endfunction

  function automatic void sin_cos(input longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = longint'(64'd1 << 56);
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q60[i];
      end else begin
        x += dx; y -= dy; z += arctan_q60[i];
      end
    end
    c = x - mul_q60(y, z);
    s = y + mul_q60(x, z);
  endfunction

  function automatic longint polar(input longint x, input longint y, output longint ang);
    longint z, dx, dy, q;
    logic [127:0] num;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_q60[i];
      end else begin
        x -= dx; y += dy; z -= arctan_q60[i];
      end
    end
    if (x > 0 && abs64(y) < 64'(x)) begin
      num = {64'd0, abs64(y)} << 60;
      num = num / {64'd0, 64'(x)};
      q = longint'(num[63:0]);
      z += y < 0 ? -q : q;
    end
    ang = z;
    return x;
  endfunction

  function automatic longint clamp_lat(input longint v);
    longint lim;
    lim = longint'(64'd90 << FRAC);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [34:0] haversine_mm(input longint lat1, input longint lon1,
                                               input longint lat2, input longint lon2,
                                               input logic [22:0] radius);
    longint per, dl, cd, sd, cm, sm, cl, sl, m1, m2, psi, c, unused_ang;
    logic [63:0] u1, v1, u2, v2, dist_mm;
    lat1 = clamp_lat(lat1);
    lat2 = clamp_lat(lat2);
    per = longint'(64'd360 << FRAC);
    dl = (lon2 - lon1) % per;
    if (dl < 0) dl += per;
    if (dl >= per / 2) dl -= per;
    sin_cos(to_half_rad(lat2 - lat1), cd, sd);
    sin_cos(to_half_rad(lat1 + lat2), cm, sm);
    sin_cos(to_half_rad(dl), cl, sl);
    u1 = mul_shr(abs64(sd), abs64(cl), 56, 1'b0);
    v1 = mul_shr(abs64(cm), abs64(sl), 56, 1'b0);
    u2 = mul_shr(abs64(cd), abs64(cl), 56, 1'b0);
    v2 = mul_shr(abs64(sm), abs64(sl), 56, 1'b0);
    m1 = polar(longint'(u1), longint'(v1), unused_ang);
    m2 = polar(longint'(u2), longint'(v2), unused_ang);
    void'(polar(m2, m1, psi));
    c = 2 * psi;
    if (c < 0) c = 0;
    dist_mm = mul_shr({41'd0, radius} * 64'd1000, 64'(c), 60, 1'b1);
    if (dist_mm > 64'(MAX_MM)) dist_mm = 64'(MAX_MM);
    return dist_mm[34:0];
  endfunction

  initial begin
    longint acc, term;
    int e;
    arctan_q60[0] = longint'((PI60 + 64'd2) >> 2);
    for (int i = 1; i < STAGES; i++) begin
      acc = 0;
      for (int k = 0; k < 64; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          term = longint'((64'd1 << e) / 64'(2 * k + 1));
          acc = (k & 1) ? acc - term : acc + term;
        end
      end
      arctan_q60[i] = (acc + 2) >>> 2;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic [34:0] want;
    if (!rst_ni) begin
      radius_m = 23'd6371000;
      distance_q.delete();
      mismatch_count = 0;
      outstanding = 0;
    end else begin
      if (sphere_radius_m_we_i) radius_m = sphere_radius_m_i;
      if (start_i && !busy_o) begin
        distance_q.insert(distance_q.size(),
                          haversine_mm(first_latitude_i, first_longitude_i,
                                       second_latitude_i, second_longitude_i, radius_m));
      end
      if (done_o) begin
        if (distance_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result distance_mm=%0d", distance_mm_o);
        end else begin
          want = distance_q.pop_front();
          if (want !== distance_mm_o) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("distance_mm expected %0d got %0d", want, distance_mm_o);
          end
        end
      end
      outstanding = distance_q.size();
    end
  end

endmodule

>>> tb/sv/great_circle_distance_test.sv
`timescale 1ns / 100ps

module great_circle_distance_test;

  localparam longint LAT_MAX = 754974720;
  localparam longint LON_MAX = 1509949440;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN = 200;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [30:0] first_latitude_i = '0;
  logic signed [31:0] first_longitude_i = '0;
  logic signed [30:0] second_latitude_i = '0;
  logic signed [31:0] second_longitude_i = '0;
  logic               sphere_radius_m_we_i = 1'b0;
  logic [22:0]        sphere_radius_m_i = '0;
  logic               done_o;
  logic [34:0]        distance_mm_o;
  int                 mismatch_count;
  int                 outstanding;
  int                 cycles = 0;
  int                 idle_pct = 0;

  great_circle_distance i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .first_latitude_i, .first_longitude_i, .second_latitude_i, .second_longitude_i,
    .sphere_radius_m_we_i, .sphere_radius_m_i, .done_o, .distance_mm_o
  );

  great_circle_distance_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .first_latitude_i, .first_longitude_i, .second_latitude_i, .second_longitude_i,
    .sphere_radius_m_we_i, .sphere_radius_m_i, .done_o, .distance_mm_o,
    .mismatch_count, .outstanding
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_points(input longint lat1, input longint lon1,
                             input longint lat2, input longint lon2);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    first_latitude_i <= 31'(lat1);
    first_longitude_i <= 32'(lon1);
    second_latitude_i <= 31'(lat2);
    second_longitude_i <= 32'(lon2);
    taken = 1'b0;
    while (!taken) begin
      taken = !busy_o;
      @(posedge clk_i);
    end
  endtask

  task automatic set_radius(input logic [22:0] r);
    start_i <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    sphere_radius_m_we_i <= 1'b1;
    sphere_radius_m_i <= r;
    @(posedge clk_i);
    sphere_radius_m_we_i <= 1'b0;
  endtask

  function automatic longint rand_lat();
    return longint'($urandom_range(0, 32'(2 * LAT_MAX))) - LAT_MAX;
  endfunction

  function automatic longint rand_lon();
    return longint'($urandom_range(0, 32'(2 * LON_MAX))) - LON_MAX;
  endfunction

  task automatic random_beat();
    int pick;
    longint la, lo;
    pick = $urandom_range(99);
    if (pick < 65) begin
      send_points(rand_lat(), rand_lon(), rand_lat(), rand_lon());
    end else if (pick < 80) begin
      send_points(longint'($signed(31'($urandom))), longint'($signed($urandom)),
                  longint'($signed(31'($urandom))), longint'($signed($urandom)));
    end else if (pick < 88) begin
      la = rand_lat();
      lo = rand_lon();
      send_points(la, lo, la + $urandom_range(0, 64) - 32, lo + $urandom_range(0, 64) - 32);
    end else if (pick < 95) begin
      la = rand_lat();
      lo = rand_lon();
      send_points(la, lo, -la, lo + LON_MAX + $urandom_range(0, 8) - 4);
    end else begin
      send_points(rand_lat(), LON_MAX - $urandom_range(0, 4),
                  rand_lat(), -LON_MAX + $urandom_range(0, 4));
    end
  endtask

  initial begin
    logic [22:0] radii[6];
    radii = '{23'd6371000, 23'd6000000, 23'd7000000, 23'h7FFFFF, 23'd0, 23'd6371000};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners at the reset radius
    send_points(0, 0, 0, 0);
    send_points(LAT_MAX, 0, -LAT_MAX, 0);
    send_points(0, 0, 0, LON_MAX);
    send_points(0, -LON_MAX, 0, LON_MAX);
    send_points(0, LON_MAX, 0, -LON_MAX);
    send_points(0, 0, 0, LON_MAX - 1);
    send_points(0, 0, 0, -LON_MAX);
    send_points(LAT_MAX, 123456, LAT_MAX, -987654);
    send_points(-LAT_MAX, 0, -LAT_MAX, LON_MAX);
    send_points(-(1 << 30), 0, (1 << 30) - 1, 0);
    send_points(-(1 << 30), -(64'sd1 << 31), (1 << 30) - 1, (64'sd1 << 31) - 1);
    send_points((1 << 30) - 1, (64'sd1 << 31) - 1, -(1 << 30), -(64'sd1 << 31));
    send_points(LAT_MAX + 1, 0, 0, 0);
    send_points(0, 0, 1, 1);
    send_points(-1, -1, 0, 0);
    send_points(LAT_MAX / 2, LON_MAX / 2, -LAT_MAX / 2, -LON_MAX / 2);
    send_points(12345678, 0, -12345678, LON_MAX);
    send_points(0, 0, 0, 3 * LON_MAX);

    for (int ph = 0; ph < 6; ph++) begin
      set_radius(ph == 5 ? 23'($urandom_range(6000000, 7000000)) : radii[ph]);
      idle_pct = ph < 2 ? 38 : (ph < 4 ? 66 : 0);
      send_points(0, 0, 0, LON_MAX);
      for (int n = 0; n < 330; n++) random_beat();
    end

    start_i <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
